[src/nsf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence filter package
// Shared payload types, command structure, codes and header character tables.
// ----------------------------------------------------------------------------
package nsf_pkg;

    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam int         HDR_LEN     = 6;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } nsf_in_t;

    typedef struct packed {
        logic       sentence_done;
        logic [6:0] sentence_length;
        logic [7:0] read_data;
    } nsf_out_t;

    // Control bits of one command passed from the front end to the back end.
    typedef struct packed {
        logic write_en;
        logic read_en;
        logic done;
    } nsf_ctrl_t;

    // Expected characters of "$GPGGA" by position.
    function automatic logic [7:0] gga_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected characters of "$GPRMC" by position.
    function automatic logic [7:0] rmc_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[src/nsf_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence filter stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface nsf_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/nsf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence filter front end
// Accepts items, tracks the sentence being received, matches the header and
// turns every item into one memory command for the back end.
// ----------------------------------------------------------------------------
module nsf_front
    import nsf_pkg::*;
#(
    parameter int BUF_DEPTH = 128,
    parameter int CNT_W     = $clog2(BUF_DEPTH),
    parameter int ADDR_W    = CNT_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    nsf_stream_if.sink         req,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output nsf_ctrl_t          cmd_ctrl,
    output logic [ADDR_W-1:0]  cmd_addr,
    output logic [7:0]         cmd_wdata,
    output logic [6:0]         cmd_len
);

    localparam int IDX_W = (CNT_W > 7) ? CNT_W : 7;

    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic             fill_half_reg, fill_half_next;
    logic [CNT_W-1:0] fin_len_reg, fin_len_next;
    logic             gga_ok_reg, gga_ok_next;
    logic             rmc_ok_reg, rmc_ok_next;

    logic             fire;
    logic             gga_m, rmc_m;
    logic [CNT_W-1:0] cnt_inc;
    logic [IDX_W-1:0] idx_w;
    logic [7:0]       ch;

    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;
    assign fire      = req.valid && req.ready;
    assign ch        = req.data.rx_byte;
    assign cmd_wdata = ch;
    assign cmd_len   = 7'(fin_len_next);

    always_comb
    begin
        fill_count_next = fill_count_reg;
        fill_half_next  = fill_half_reg;
        fin_len_next    = fin_len_reg;
        gga_ok_next     = gga_ok_reg;
        rmc_ok_next     = rmc_ok_reg;
        cmd_ctrl        = '0;
        cmd_addr        = '0;
        cnt_inc         = fill_count_reg + 1'b1;
        idx_w           = IDX_W'(req.data.read_index);
        // The first header position starts a fresh match; later ones extend it.
        gga_m = ((fill_count_reg == '0) || gga_ok_reg)
                && (ch == gga_char(fill_count_reg[2:0]));
        rmc_m = ((fill_count_reg == '0) || rmc_ok_reg)
                && (ch == rmc_char(fill_count_reg[2:0]));

        if (req.data.operation == OP_READ)
        begin
            cmd_ctrl.read_en = (idx_w < IDX_W'(fin_len_reg));
            cmd_addr         = {~fill_half_reg, idx_w[CNT_W-1:0]};
        end
        else if (!((fill_count_reg == '0) && (ch != CHAR_DOLLAR)))
        begin
            cmd_ctrl.write_en = 1'b1;
            cmd_addr          = {fill_half_reg, fill_count_reg};
            if (fill_count_reg < CNT_W'(HDR_LEN))
            begin
                gga_ok_next = gga_m;
                rmc_ok_next = rmc_m;
            end
            if ((fill_count_reg == CNT_W'(HDR_LEN - 1)) && !(gga_m || rmc_m))
            begin
                fill_count_next = '0;
            end
            else if ((fill_count_reg > CNT_W'(HDR_LEN - 1)) && (ch == CHAR_CR))
            begin
                fin_len_next    = cnt_inc;
                fill_half_next  = ~fill_half_reg;
                fill_count_next = '0;
                cmd_ctrl.done   = 1'b1;
            end
            else if (cnt_inc == CNT_W'(BUF_DEPTH - 1))
            begin
                // Sentence too long for one half: drop it silently.
                fill_count_next = '0;
            end
            else
            begin
                fill_count_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            fill_half_reg  <= 1'b0;
            fin_len_reg    <= '0;
            gga_ok_reg     <= 1'b0;
            rmc_ok_reg     <= 1'b0;
        end
        else if (fire)
        begin
            fill_count_reg <= fill_count_next;
            fill_half_reg  <= fill_half_next;
            fin_len_reg    <= fin_len_next;
            gga_ok_reg     <= gga_ok_next;
            rmc_ok_reg     <= rmc_ok_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_swaps_half: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd_ctrl.done |=> fill_half_reg != $past(fill_half_reg))
        else $error("completed sentence did not swap buffer halves");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg < CNT_W'(BUF_DEPTH - 1))
        else $error("fill count reached the overflow limit");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !(cmd_ctrl.write_en && cmd_ctrl.read_en))
        else $error("command both writes and reads the store");

    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cmd_ctrl.done |=> fin_len_reg == $past(fin_len_reg))
        else $error("latched length changed without a completed sentence");
`endif

endmodule
`default_nettype wire

[src/nsf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence filter command queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module nsf_queue
    import nsf_pkg::*;
#(
    parameter int ADDR_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  nsf_ctrl_t          push_ctrl,
    input  logic [ADDR_W-1:0]  push_addr,
    input  logic [7:0]         push_wdata,
    input  logic [6:0]         push_len,
    output logic               pop_valid,
    input  logic               pop_ready,
    output nsf_ctrl_t          pop_ctrl,
    output logic [ADDR_W-1:0]  pop_addr,
    output logic [7:0]         pop_wdata,
    output logic [6:0]         pop_len
);

    nsf_ctrl_t         ctrl_q  [2];
    logic [ADDR_W-1:0] addr_q  [2];
    logic [7:0]        wdata_q [2];
    logic [6:0]        len_q   [2];

    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign pop_ctrl  = ctrl_q[rd_ptr_reg];
    assign pop_addr  = addr_q[rd_ptr_reg];
    assign pop_wdata = wdata_q[rd_ptr_reg];
    assign pop_len   = len_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_q[wr_ptr_reg]  <= push_ctrl;
            addr_q[wr_ptr_reg]  <= push_addr;
            wdata_q[wr_ptr_reg] <= push_wdata;
            len_q[wr_ptr_reg]   <= push_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/nsf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence filter back end
// Executes queued commands on the two-half sentence store and registers the
// result item toward the output channel.
// ----------------------------------------------------------------------------
module nsf_back
    import nsf_pkg::*;
#(
    parameter int ADDR_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  nsf_ctrl_t          cmd_ctrl,
    input  logic [ADDR_W-1:0]  cmd_addr,
    input  logic [7:0]         cmd_wdata,
    input  logic [6:0]         cmd_len,
    nsf_stream_if.source       rsp
);

    localparam int MEM_DEPTH = 2 ** ADDR_W;

    logic [7:0] store_mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;

    logic       out_valid_reg;
    logic       out_done_reg;
    logic       out_read_reg;
    logic [6:0] out_len_reg;
    logic       take;

    // The output register frees up when its result is transferred.
    assign cmd_ready = !out_valid_reg || rsp.ready;
    assign take      = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (take && cmd_ctrl.write_en)
        begin
            store_mem[cmd_addr] <= cmd_wdata;
        end
        if (take && cmd_ctrl.read_en)
        begin
            rd_data_reg <= store_mem[cmd_addr];
        end
        if (take)
        begin
            out_done_reg <= cmd_ctrl.done;
            out_read_reg <= cmd_ctrl.read_en;
            out_len_reg  <= cmd_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    assign rsp.valid                = out_valid_reg;
    assign rsp.data.sentence_done   = out_done_reg;
    assign rsp.data.sentence_length = out_len_reg;
    assign rsp.data.read_data       = out_read_reg ? rd_data_reg : 8'h00;

endmodule
`default_nettype wire

[src/nmea_sentence_filter_receiver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence filter receiver
// Collects "$GPGGA" and "$GPRMC" sentences into a double buffer and serves
// byte reads of the last finished sentence.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while the command queue has room;
// every item yields one result, registered by the back end. The rate is set
// by the single port of the sentence store, which each item uses at most once,
// and by the two-entry command queue between the header matcher and the store,
// which lets the input keep flowing while a result waits to be taken. The
// store needs no clearing pass: only bytes below the latched sentence length
// are ever read, and those were written by that sentence.
module nmea_sentence_filter_receiver
    import nsf_pkg::*;
#(
    parameter int BUF_DEPTH = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    nsf_stream_if.sink   req,
    nsf_stream_if.source rsp
);

    localparam int CNT_W  = $clog2(BUF_DEPTH);
    localparam int ADDR_W = CNT_W + 1;

    logic              f_valid, f_ready;
    nsf_ctrl_t         f_ctrl;
    logic [ADDR_W-1:0] f_addr;
    logic [7:0]        f_wdata;
    logic [6:0]        f_len;

    logic              b_valid, b_ready;
    nsf_ctrl_t         b_ctrl;
    logic [ADDR_W-1:0] b_addr;
    logic [7:0]        b_wdata;
    logic [6:0]        b_len;

    nsf_front #(
        .BUF_DEPTH (BUF_DEPTH),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_ctrl  (f_ctrl),
        .cmd_addr  (f_addr),
        .cmd_wdata (f_wdata),
        .cmd_len   (f_len)
    );

    nsf_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_ctrl  (f_ctrl),
        .push_addr  (f_addr),
        .push_wdata (f_wdata),
        .push_len   (f_len),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_ctrl   (b_ctrl),
        .pop_addr   (b_addr),
        .pop_wdata  (b_wdata),
        .pop_len    (b_len)
    );

    nsf_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_ctrl  (b_ctrl),
        .cmd_addr  (b_addr),
        .cmd_wdata (b_wdata),
        .cmd_len   (b_len),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

[tb/sv/nmea_sentence_filter_receiver_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence filter receiver checker
// Watches both channels of the receiver, keeps its own copy of the sentence
// store and fill state, works out the result of every accepted command and
// compares each returned result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module nmea_sentence_filter_receiver_checker
    import nsf_pkg::*;
#(
    parameter int BUF_DEPTH = 128
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  nsf_in_t  in_item,
    input  logic     out_valid,
    input  logic     out_ready,
    input  nsf_out_t out_item,
    output int       fail_count,
    output int       pending_results
);

    localparam logic [47:0] GGA_HEADER = "$GPGGA";
    localparam logic [47:0] RMC_HEADER = "$GPRMC";

    logic [6:0] fill_count;
    logic       fill_half;
    logic [6:0] finished_length;
    logic [7:0] sentence_mem [0:2*BUF_DEPTH-1];
    nsf_out_t   expected_results [$];

    initial
    begin
        fill_count      = '0;
        fill_half       = 1'b0;
        finished_length = '0;
        fail_count      = 0;
        pending_results = 0;
        for (int i = 0; i < 2 * BUF_DEPTH; i++)
            sentence_mem[i] = 8'h00;
    end

    // Stores one serial byte and reports whether it finished an accepted sentence.
    function automatic logic absorb_byte(input logic [7:0] ch);
        logic [47:0] header;
        header = '0;
        if (fill_count == 7'd0 && ch != CHAR_DOLLAR)
            return 1'b0;
        sentence_mem[{fill_half, fill_count}] = ch;
        if (fill_count == 7'd5)
        begin
            for (int k = 0; k < HDR_LEN; k++)
                header = {header[39:0], sentence_mem[{fill_half, 7'(k)}]};
            if (header != GGA_HEADER && header != RMC_HEADER)
            begin
                fill_count = '0;
                return 1'b0;
            end
        end
        if (fill_count > 7'd5 && ch == CHAR_CR)
        begin
            finished_length = fill_count + 7'd1;
            fill_half       = ~fill_half;
            fill_count      = '0;
            return 1'b1;
        end
        fill_count = fill_count + 7'd1;
        // A sentence that would fill the half is thrown away without notice.
        if (fill_count == 7'(BUF_DEPTH - 1))
            fill_count = '0;
        return 1'b0;
    endfunction

    function automatic nsf_out_t compute_result(input nsf_in_t item);
        nsf_out_t res;
        res = '0;
        if (item.operation == OP_RECEIVE)
            res.sentence_done = absorb_byte(item.rx_byte);
        else if (item.read_index < finished_length)
            res.read_data = sentence_mem[{~fill_half, item.read_index}];
        res.sentence_length = finished_length;
        return res;
    endfunction

    always @(posedge clk)
    begin
        nsf_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(compute_result(in_item));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer: %p", out_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.sentence_done !== want.sentence_done)
                    begin
                        $error("sentence_done mismatch: expected %0d, actual %0d",
                               want.sentence_done, out_item.sentence_done);
                        fail_count++;
                    end
                    if (out_item.sentence_length !== want.sentence_length)
                    begin
                        $error("sentence_length mismatch: expected %0d, actual %0d",
                               want.sentence_length, out_item.sentence_length);
                        fail_count++;
                    end
                    if (out_item.read_data !== want.read_data)
                    begin
                        $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                               want.read_data, out_item.read_data);
                        fail_count++;
                    end
                end
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

[tb/sv/nmea_sentence_filter_receiver_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence filter receiver testbench
// Feeds the receiver with GGA and RMC sentences of random content and length,
// broken headers, early carriage returns, overflows, line noise and reads of
// the finished sentence, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module nmea_sentence_filter_receiver_test;
    import nsf_pkg::*;

    localparam int          BUF_DEPTH   = 128;
    localparam int          HOLD_CYCLES = 300;
    localparam int          ITEM_TARGET = 950;
    localparam logic [47:0] GGA_HEADER  = "$GPGGA";
    localparam logic [47:0] RMC_HEADER  = "$GPRMC";

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   hold_seq;
    int   item_count;
    int   fail_count;
    int   pending_results;

    nsf_stream_if #(.payload_t(nsf_in_t))  req_if ();
    nsf_stream_if #(.payload_t(nsf_out_t)) rsp_if ();

    nmea_sentence_filter_receiver #(
        .BUF_DEPTH(BUF_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    nmea_sentence_filter_receiver_checker #(
        .BUF_DEPTH(BUF_DEPTH)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (req_if.valid),
        .in_ready        (req_if.ready),
        .in_item         (req_if.data),
        .out_valid       (rsp_if.valid),
        .out_ready       (rsp_if.ready),
        .out_item        (rsp_if.data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off each time it is asked for.
    initial
    begin
        int served;
        served = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != served)
            begin
                served = hold_seq;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    task automatic push_item(input op_t op, input logic [7:0] ch, input logic [6:0] idx,
                             input bit counts);
        while (!no_idle && $urandom_range(99) < 12)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= nsf_in_t'{operation: op, rx_byte: ch, read_index: idx};
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (counts)
            item_count++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        push_item(OP_RECEIVE, ch, 7'($urandom_range(127)), 1'b1);
    endtask

    task automatic send_read(input logic [6:0] idx);
        push_item(OP_READ, 8'($urandom_range(255)), idx, 1'b1);
    endtask

    task automatic send_header(input logic [47:0] header);
        for (int k = 0; k < HDR_LEN; k++)
            send_byte(header[47 - 8 * k -: 8]);
    endtask

    // Body bytes never hold a carriage return, so the length is under control.
    task automatic send_body(input int count);
        logic [7:0] ch;
        for (int k = 0; k < count; k++)
        begin
            do
                ch = 8'($urandom_range(255));
            while (ch == CHAR_CR);
            send_byte(ch);
        end
    endtask

    task automatic wait_drained;
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic send_sentence_with_reads;
        int body;
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 78)
            body = $urandom_range(20);
        else if (pick < 92)
            body = $urandom_range(100, 119);
        else
            body = 120;
        send_header($urandom_range(1) ? RMC_HEADER : GGA_HEADER);
        send_body(body);
        send_byte(CHAR_CR);
        len = body + 7;
        repeat ($urandom_range(4))
            send_read(7'($urandom_range((len + 1 > 127) ? 127 : len + 1)));
    endtask

    task automatic send_broken_header;
        logic [47:0] header;
        int          pos;
        logic [7:0]  ch;
        header = $urandom_range(1) ? RMC_HEADER : GGA_HEADER;
        pos    = $urandom_range(1, 5);
        do
            ch = 8'($urandom_range(255));
        while (ch == header[47 - 8 * pos -: 8]);
        header[47 - 8 * pos -: 8] = ch;
        send_header(header);
        send_body($urandom_range(3));
        send_byte(CHAR_CR);
    endtask

    // A carriage return inside the header is stored as data and spoils it.
    task automatic send_early_cr;
        int pos;
        pos = $urandom_range(1, 5);
        for (int k = 0; k < pos; k++)
            send_byte(GGA_HEADER[47 - 8 * k -: 8]);
        send_byte(CHAR_CR);
        send_body($urandom_range(2));
        send_byte(CHAR_CR);
    endtask

    task automatic send_overflow;
        send_header($urandom_range(1) ? RMC_HEADER : GGA_HEADER);
        send_body($urandom_range(121, 135));
        send_byte(CHAR_CR);
        send_read(7'($urandom_range(127)));
    endtask

    initial
    begin
        int pick;
        int next_drain;
        rst_n        = 1'b0;
        no_idle      = 1'b0;
        hold_seq     = 0;
        item_count   = 0;
        next_drain   = 200;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reads before any sentence, ignored bytes, the shortest
        // sentence with reads at its edges, a one-byte body and a bad header.
        push_item(OP_READ, 8'hFF, 7'd0, 1'b1);
        push_item(OP_READ, 8'h00, 7'd127, 1'b1);
        push_item(OP_RECEIVE, 8'h00, 7'd127, 1'b1);
        push_item(OP_RECEIVE, 8'hFF, 7'd0, 1'b1);
        send_byte(CHAR_CR);
        send_header(GGA_HEADER);
        send_byte(CHAR_CR);
        send_read(7'd0);
        send_read(7'd6);
        send_read(7'd7);
        send_read(7'd127);
        send_header(RMC_HEADER);
        send_byte(8'h80);
        send_byte(CHAR_CR);
        send_read(7'd6);
        send_read(7'd7);
        send_header("$GPXMC");
        send_read(7'd5);
        wait_drained();

        // The result side holds off while sentences keep coming, so the input stalls.
        hold_seq++;
        repeat (3)
            send_sentence_with_reads();
        wait_drained();

        while (item_count < ITEM_TARGET)
        begin
            no_idle = (item_count >= 400 && item_count < 550);
            pick = $urandom_range(99);
            if (pick < 55)
                send_sentence_with_reads();
            else if (pick < 68)
                repeat ($urandom_range(1, 3))
                    send_read(7'($urandom_range(127)));
            else if (pick < 78)
                send_broken_header();
            else if (pick < 86)
                send_early_cr();
            else if (pick < 94)
                repeat ($urandom_range(1, 4))
                    push_item(OP_RECEIVE, 8'($urandom_range(255)),
                              7'($urandom_range(127)), 1'b0);
            else
                send_overflow();
            if (item_count >= next_drain)
            begin
                next_drain += 200;
                wait_drained();
            end
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
